>>> hdl/rtc3w_pkg.sv
package rtc3w_pkg;

    // Command codes carried in the cmd field of an input beat.
    localparam logic [1:0] CMD_IDLE  = 2'd0;
    localparam logic [1:0] CMD_WRITE = 2'd1;
    localparam logic [1:0] CMD_READ  = 2'd2;

    // Transaction sequencer phases.
    typedef enum logic [3:0] {
        PH_IDLE    = 4'd0,
        PH_SETBIT  = 4'd1,
        PH_CLKHI   = 4'd2,
        PH_CLKLO   = 4'd3,
        PH_FINISH  = 4'd4,
        PH_RELEASE = 4'd5,
        PH_SAMPLE  = 4'd6,
        PH_RXHI    = 4'd7,
        PH_RXLO    = 4'd8
    } t_phase;

    // One input beat: one tick of the bus master.
    typedef struct packed {
        logic [1:0] cmd;
        logic [7:0] reg_addr;
        logic [6:0] wr_value;
        logic       io_in;
    } t_in_item;

    // One output beat: pin levels and status after the tick.
    typedef struct packed {
        logic       ce;
        logic       sclk;
        logic       io_out;
        logic       io_drive;
        logic       busy_res;
        logic       done_res;
        logic [7:0] rd_value;
    } t_out_item;

endpackage

>>> hdl/rtc3w_core.sv
module rtc3w_core (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_step,
    input  rtc3w_pkg::t_in_item   i_item,
    output rtc3w_pkg::t_out_item  o_result
);

    // Decimal 0..127 to two BCD digits; the tens digit may exceed nine.
    function automatic logic [7:0] to_bcd(input logic [6:0] v);
        logic [14:0] prod;
        logic [3:0]  tens;
        logic [6:0]  rem;
        prod = 15'(v) * 15'd205;
        tens = prod[14:11];
        rem  = v - 7'(tens) * 7'd10;
        return {tens, rem[3:0]};
    endfunction

    // BCD byte to decimal, high nibble times ten plus low nibble.
    function automatic logic [7:0] from_bcd(input logic [7:0] b);
        return 8'(b[7:4] * 8'd10) + {4'd0, b[3:0]};
    endfunction

    rtc3w_pkg::t_phase r_phase, n_phase;
    logic [2:0] r_bit_index, n_bit_index;
    logic [7:0] r_tx_shift, n_tx_shift;
    logic [7:0] r_rx_shift, n_rx_shift;
    logic [7:0] r_data_bcd, n_data_bcd;
    logic       r_is_read, n_is_read;
    logic       r_second_byte, n_second_byte;
    logic       r_ce, n_ce;
    logic       r_sclk, n_sclk;
    logic       r_io, n_io;
    logic       r_drive, n_drive;
    logic [7:0] r_last_read, n_last_read;
    logic       n_done;
    logic       start;

    assign start = (i_item.cmd == rtc3w_pkg::CMD_WRITE) ||
                   (i_item.cmd == rtc3w_pkg::CMD_READ);

    // Next phase of the sequencer.
    always_comb begin
        n_phase = rtc3w_pkg::PH_IDLE;
        case (r_phase)
            rtc3w_pkg::PH_SETBIT: n_phase = rtc3w_pkg::PH_CLKHI;
            rtc3w_pkg::PH_CLKHI:  n_phase = rtc3w_pkg::PH_CLKLO;
            rtc3w_pkg::PH_CLKLO: begin
                if (r_bit_index != 3'd7) begin
                    n_phase = rtc3w_pkg::PH_SETBIT;
                end else if (r_is_read) begin
                    n_phase = rtc3w_pkg::PH_RELEASE;
                end else if (!r_second_byte) begin
                    n_phase = rtc3w_pkg::PH_SETBIT;
                end else begin
                    n_phase = rtc3w_pkg::PH_FINISH;
                end
            end
            rtc3w_pkg::PH_FINISH:  n_phase = rtc3w_pkg::PH_IDLE;
            rtc3w_pkg::PH_RELEASE: n_phase = rtc3w_pkg::PH_SAMPLE;
            rtc3w_pkg::PH_SAMPLE: begin
                n_phase = (r_bit_index != 3'd7) ? rtc3w_pkg::PH_RXHI : rtc3w_pkg::PH_IDLE;
            end
            rtc3w_pkg::PH_RXHI: n_phase = rtc3w_pkg::PH_RXLO;
            rtc3w_pkg::PH_RXLO: n_phase = rtc3w_pkg::PH_SAMPLE;
            default: begin
                n_phase = start ? rtc3w_pkg::PH_SETBIT : rtc3w_pkg::PH_IDLE;
            end
        endcase
    end

    // Pin levels, shift registers and counters for this tick.
    always_comb begin
        n_bit_index   = r_bit_index;
        n_tx_shift    = r_tx_shift;
        n_rx_shift    = r_rx_shift;
        n_data_bcd    = r_data_bcd;
        n_is_read     = r_is_read;
        n_second_byte = r_second_byte;
        n_ce          = r_ce;
        n_sclk        = r_sclk;
        n_io          = r_io;
        n_drive       = r_drive;
        n_last_read   = r_last_read;
        n_done        = 1'b0;
        case (r_phase)
            rtc3w_pkg::PH_SETBIT: begin
                n_io    = r_tx_shift[r_bit_index];
                n_drive = 1'b1;
            end
            rtc3w_pkg::PH_CLKHI: n_sclk = 1'b1;
            rtc3w_pkg::PH_CLKLO: begin
                n_sclk = 1'b0;
                if (r_bit_index != 3'd7) begin
                    n_bit_index = r_bit_index + 3'd1;
                end else begin
                    n_bit_index = 3'd0;
                    if (!r_is_read && !r_second_byte) begin
                        n_second_byte = 1'b1;
                        n_tx_shift    = r_data_bcd;
                    end
                end
            end
            rtc3w_pkg::PH_FINISH: begin
                n_ce   = 1'b0;
                n_done = 1'b1;
            end
            rtc3w_pkg::PH_RELEASE: begin
                n_drive     = 1'b0;
                n_bit_index = 3'd0;
            end
            rtc3w_pkg::PH_SAMPLE: begin
                if (i_item.io_in) begin
                    n_rx_shift[r_bit_index] = 1'b1;
                end
                if (r_bit_index == 3'd7) begin
                    n_ce        = 1'b0;
                    n_last_read = from_bcd(n_rx_shift);
                    n_done      = 1'b1;
                    n_bit_index = 3'd0;
                end
            end
            rtc3w_pkg::PH_RXHI: n_sclk = 1'b1;
            rtc3w_pkg::PH_RXLO: begin
                n_sclk      = 1'b0;
                n_bit_index = r_bit_index + 3'd1;
            end
            default: begin
                if (start) begin
                    n_is_read     = (i_item.cmd == rtc3w_pkg::CMD_READ);
                    n_second_byte = 1'b0;
                    n_bit_index   = 3'd0;
                    n_rx_shift    = 8'd0;
                    n_data_bcd    = to_bcd(i_item.wr_value);
                    n_tx_shift    = (i_item.cmd == rtc3w_pkg::CMD_READ) ?
                                    i_item.reg_addr + 8'd1 : i_item.reg_addr;
                    n_ce          = 1'b1;
                end
            end
        endcase
    end

    // Result of this tick as seen after the state update.
    always_comb begin
        o_result.ce       = n_ce;
        o_result.sclk     = n_sclk;
        o_result.io_out   = n_io;
        o_result.io_drive = n_drive;
        o_result.busy_res = (n_phase != rtc3w_pkg::PH_IDLE);
        o_result.done_res = n_done;
        o_result.rd_value = n_last_read;
    end

    // State registers advance once per accepted tick.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= rtc3w_pkg::PH_IDLE;
            r_bit_index   <= 3'd0;
            r_tx_shift    <= 8'd0;
            r_rx_shift    <= 8'd0;
            r_data_bcd    <= 8'd0;
            r_is_read     <= 1'b0;
            r_second_byte <= 1'b0;
            r_ce          <= 1'b0;
            r_sclk        <= 1'b0;
            r_io          <= 1'b0;
            r_drive       <= 1'b0;
            r_last_read   <= 8'd0;
        end else if (i_step) begin
            r_phase       <= n_phase;
            r_bit_index   <= n_bit_index;
            r_tx_shift    <= n_tx_shift;
            r_rx_shift    <= n_rx_shift;
            r_data_bcd    <= n_data_bcd;
            r_is_read     <= n_is_read;
            r_second_byte <= n_second_byte;
            r_ce          <= n_ce;
            r_sclk        <= n_sclk;
            r_io          <= n_io;
            r_drive       <= n_drive;
            r_last_read   <= n_last_read;
        end
    end

endmodule

>>> hdl/rtc3w_out_reg.sv
module rtc3w_out_reg (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_load,
    input  rtc3w_pkg::t_out_item  i_data,
    output logic                  o_valid,
    input  logic                  i_ready,
    output rtc3w_pkg::t_out_item  o_data
);

    logic                 r_valid;
    rtc3w_pkg::t_out_item r_data;

    // Valid flag: set by a new result, cleared when the beat is taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    // Result payload.
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_data <= i_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

>>> hdl/three_wire_rtc_serial_master.sv
// Three-wire serial bus master for a real-time-clock chip. Each input beat is
// one tick of the bus: a write command raises chip enable and shifts out the
// address byte and the BCD form of the value, a read command sends the address
// plus one, releases the data line and samples eight bits, and every tick
// returns exactly one output beat with the pin levels and status after it.
// One beat is taken every clock cycle while the result register is free or being
// drained; a beat is held in the input register, and its result is written to the
// result register when the beat moves on, where it waits until it is taken. The
// tick-to-tick state lives in a single sequencer that updates once per accepted
// beat, which is what sets this rate. Commands that arrive while busy are
// ignored.
module three_wire_rtc_serial_master (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  rtc3w_pkg::t_in_item   i_in_data,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output rtc3w_pkg::t_out_item  o_out_data
);

    logic                 r_in_valid;
    rtc3w_pkg::t_in_item  r_in_data;
    logic                 advance;
    rtc3w_pkg::t_out_item result;

    // A held tick moves on when the result register is free or draining.
    assign advance    = r_in_valid && (!o_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || advance;

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in_data <= i_in_data;
        end
    end

    rtc3w_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (advance),
        .i_item   (r_in_data),
        .o_result (result)
    );

    rtc3w_out_reg u_out_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (advance),
        .i_data  (result),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_data  (o_out_data)
    );

endmodule

>>> hdl/rtc3w_checker.sv
module rtc3w_checker (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  i_in_valid,
    input logic                  o_in_ready,
    input rtc3w_pkg::t_in_item   i_in_data,
    input logic                  o_out_valid,
    input logic                  i_out_ready,
    input rtc3w_pkg::t_out_item  o_out_data
);

    // The serial clock only pulses inside a transaction.
    a_sclk_needs_ce: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.sclk |-> o_out_data.ce)
        else $error("sclk high while ce low");

    // Chip enable stays high for as long as a transaction runs.
    a_busy_needs_ce: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.busy_res |-> o_out_data.ce)
        else $error("busy without ce");

    // The tick that ends a transaction shows the bus idle.
    a_done_not_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.done_res |-> !o_out_data.busy_res && !o_out_data.ce)
        else $error("done while busy or ce high");

    // A stalled result beat holds.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("result beat changed while stalled");

    // A stalled input beat holds.
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_ready |=> i_in_valid && $stable(i_in_data))
        else $error("input beat changed while stalled");

endmodule

bind three_wire_rtc_serial_master rtc3w_checker u_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .i_in_data   (i_in_data),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_data  (o_out_data)
);
